/* rtl/assert_macros.svh */
// shared assertion shorthands, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// consequence must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/hsi_pkg.sv */
`default_nettype none

package hsi_pkg;

    localparam int VALUE_W = 31;
    localparam int FUNC_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_HRD   = 7'b0001000,
        ST_HCHK  = 7'b0010000,
        ST_ECHK  = 7'b0100000,
        ST_INS   = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

/* rtl/hsi_ram.sv */
`default_nettype none

module hsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/hash_set_intersection.sv */
`default_nettype none
// Chained hash set intersection engine.
// Command channel: raise start with func and value while busy is low; the
// transaction is taken at that edge and busy rises, but for func 3, until
// the item is done. func 0 adds value to set A, 1 adds it to set B, 2
// clears the table, 3 is ignored at once. A value is kept once, in bucket
// value mod BUCKETS, on a linked chain, with one flag per set.
// Result channel: done is high for one cycle with common_value and
// table_full; table_full 0 means the value just joined both sets, 1 means
// the table was full and the value was dropped. The receiver cannot stall.
// Timing: an add first reduces value mod BUCKETS in a shared fold unit, one
// fold of the high part per cycle until it is zero, then one compare and
// subtract (ST_DIV). Then the bucket head is read (ST_HRD, ST_HCHK), the
// chain is walked one entry at a time (ST_ECHK) and a new value is inserted
// (ST_INS), with busy high throughout. The result is given in the first
// cycle with busy low.
// A clear, and the pass that follows reset, writes every bucket head once,
// with busy high throughout.
// At most one result per item, given in arrival order.
module hash_set_intersection
    import hsi_pkg::*;
#(
    parameter int BUCKETS     = 1021,
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    done,
    output logic [VALUE_W-1:0]      common_value,
    output logic                    table_full
);

    localparam int BA_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EA_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PTR_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = VALUE_W + PTR_W + 2;
    localparam logic [VALUE_W-1:0] FOLD_K = VALUE_W'((1 << BA_W) - BUCKETS);

    state_t               state_reg, state_next;
    logic [FUNC_W-1:0]    func_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [VALUE_W-1:0]   red_reg, red_next;
    logic [BA_W-1:0]      rem_reg, rem_next;
    logic [BA_W-1:0]      clr_idx_reg, clr_idx_next;
    logic [PTR_W-1:0]     count_reg, count_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     steps_reg, steps_next;
    logic                 done_reg, done_next;
    logic [VALUE_W-1:0]   cval_reg, cval_next;
    logic                 full_reg, full_next;

    logic                 bkt_we;
    logic [BA_W-1:0]      bkt_waddr;
    logic [PTR_W-1:0]     bkt_wdata, bkt_rdata;
    logic                 ent_we;
    logic [EA_W-1:0]      ent_waddr, ent_raddr;
    logic [ENT_W-1:0]     ent_wdata, ent_rdata;

    logic [VALUE_W-BA_W-1:0] red_hi;
    logic [BA_W-1:0]      red_lo;
    logic [VALUE_W-1:0]   red_fold;
    logic [1:0]           set_bit;
    logic [VALUE_W-1:0]   ent_value;
    logic [PTR_W-1:0]     ent_link;
    logic [1:0]           ent_flags;
    logic [1:0]           new_flags;
    logic [PTR_W-1:0]     link_m1;

    // address of the entry now on the read port, kept for the flag update
    logic [EA_W-1:0]      ent_raddr_hold;

    assign set_bit   = (func_reg == FUNC_ADD_B) ? 2'b10 : 2'b01;
    assign ent_value = ent_rdata[ENT_W-1 -: VALUE_W];
    assign ent_link  = ent_rdata[2 +: PTR_W];
    assign ent_flags = ent_rdata[1:0];
    assign new_flags = ent_flags | set_bit;

    // shared fold: x mod B equals (x >> k) * (2^k - B) + (x mod 2^k) mod B
    assign red_hi   = red_reg[VALUE_W-1:BA_W];
    assign red_lo   = red_reg[BA_W-1:0];
    assign red_fold = ({{BA_W{1'b0}}, red_hi} * FOLD_K)
                      + {{(VALUE_W-BA_W){1'b0}}, red_lo};

    hsi_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS), .AW(BA_W)) u_bucket (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (rem_reg),
        .rdata (bkt_rdata)
    );

    hsi_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES), .AW(EA_W)) u_entry (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    always_comb
    begin
        link_m1      = '0;
        state_next   = state_reg;
        red_next     = red_reg;
        rem_next     = rem_reg;
        clr_idx_next = clr_idx_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        steps_next   = steps_reg;
        done_next    = 1'b0;
        cval_next    = cval_reg;
        full_next    = full_reg;
        bkt_we       = 1'b0;
        bkt_waddr    = clr_idx_reg;
        bkt_wdata    = '0;
        ent_we       = 1'b0;
        ent_waddr    = link_m1[EA_W-1:0];
        ent_wdata    = {val_reg, ent_link, new_flags};
        ent_raddr    = link_m1[EA_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    priority if (func == FUNC_CLEAR)
                    begin
                        state_next   = ST_CLEAR;
                        clr_idx_next = '0;
                    end
                    else if (func == FUNC_NONE)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                        red_next   = value;
                    end
                end
            end
            ST_CLEAR:
            begin
                bkt_we     = 1'b1;
                count_next = '0;
                if (clr_idx_reg == BA_W'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (red_hi == '0)
                begin
                    state_next = ST_HRD;
                    if (red_lo >= BA_W'(BUCKETS))
                    begin
                        rem_next = red_lo - BA_W'(BUCKETS);
                    end
                    else
                    begin
                        rem_next = red_lo;
                    end
                end
                else
                begin
                    red_next = red_fold;
                end
            end
            ST_HRD:
            begin
                state_next = ST_HCHK;
            end
            ST_HCHK:
            begin
                head_next  = bkt_rdata;
                steps_next = '0;
                link_m1    = bkt_rdata - 1'b1;
                ent_raddr  = link_m1[EA_W-1:0];
                if (bkt_rdata == '0 || bkt_rdata > PTR_W'(MAX_ENTRIES))
                begin
                    state_next = ST_INS;
                end
                else
                begin
                    state_next = ST_ECHK;
                end
            end
            ST_ECHK:
            begin
                if (ent_value == val_reg)
                begin
                    state_next = ST_IDLE;
                    if ((ent_flags & set_bit) == 2'b00)
                    begin
                        ent_we    = 1'b1;
                        ent_waddr = ent_raddr_hold;
                        if (new_flags == 2'b11)
                        begin
                            done_next = 1'b1;
                            cval_next = val_reg;
                            full_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    link_m1    = ent_link - 1'b1;
                    ent_raddr  = link_m1[EA_W-1:0];
                    steps_next = steps_reg + 1'b1;
                    if (ent_link == '0 || ent_link > PTR_W'(MAX_ENTRIES)
                        || steps_reg == PTR_W'(MAX_ENTRIES - 1))
                    begin
                        state_next = ST_INS;
                    end
                end
            end
            ST_INS:
            begin
                state_next = ST_IDLE;
                if (count_reg == PTR_W'(MAX_ENTRIES))
                begin
                    done_next = 1'b1;
                    cval_next = val_reg;
                    full_next = 1'b1;
                end
                else
                begin
                    ent_we     = 1'b1;
                    ent_waddr  = count_reg[EA_W-1:0];
                    ent_wdata  = {val_reg, head_reg, set_bit};
                    bkt_we     = 1'b1;
                    bkt_waddr  = rem_reg;
                    bkt_wdata  = count_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            func_reg <= func;
            val_reg  <= value;
        end
        red_reg        <= red_next;
        rem_reg        <= rem_next;
        head_reg       <= head_next;
        steps_reg      <= steps_next;
        cval_reg       <= cval_next;
        full_reg       <= full_next;
        ent_raddr_hold <= ent_raddr;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign common_value = cval_reg;
    assign table_full   = full_reg;

endmodule

`default_nettype wire

/* rtl/hsi_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module hsi_checker
    import hsi_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [FUNC_W-1:0]  func,
    input wire logic               done
);

    // a taken add or clear keeps the block occupied
    `ASSERT_NEXT(a_busy_after_cmd, start && !busy && func != FUNC_NONE, busy)
    // no result can follow a new transaction straight away
    `ASSERT_NEXT(a_no_quick_result, start && !busy, !done)
    // one result per item, never two in a row
    `ASSERT_NEXT(a_single_result, done, !done)
    // a result only appears as the block returns to idle
    `ASSERT_SAME(a_result_when_idle, done, !busy)

endmodule

bind hash_set_intersection hsi_checker u_hsi_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .func  (func),
    .done  (done)
);

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import hsi_pkg::*;

    localparam int TABLE_SIZE = 1024;
    localparam int BUCKET_CNT = 1021;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [VALUE_W-1:0] val;
        logic               full;
    } hit_t;

    typedef struct {
        logic [FUNC_W-1:0]  f;
        logic [VALUE_W-1:0] v;
        bit                 typed;
        bit                 has_hit;
        logic [VALUE_W-1:0] hv;
        logic               hfull;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic               done;
    logic [VALUE_W-1:0] common_value;
    logic               table_full;

    hash_set_intersection dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .value        (value),
        .done         (done),
        .common_value (common_value),
        .table_full   (table_full)
    );

    // membership flags per stored value: bit 0 set A, bit 1 set B
    logic [1:0] member_flags [logic [VALUE_W-1:0]];
    int         stored_count;
    hit_t       pending_hits [$];
    logic [VALUE_W-1:0] stored_list [$];

    int  mismatches = 0;
    int  idle_cycles;
    int  burst_left;
    bit  failed = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // returns 1 when the transaction yields a result
    function automatic bit model_set_op(input logic [FUNC_W-1:0] f,
                                        input logic [VALUE_W-1:0] v,
                                        output hit_t hit);
        logic [1:0] mask;
        hit = '0;
        if (f == FUNC_CLEAR)
        begin
            member_flags.delete();
            stored_list.delete();
            stored_count = 0;
            return 1'b0;
        end
        if (f == FUNC_NONE)
            return 1'b0;
        mask = (f == FUNC_ADD_A) ? 2'b01 : 2'b10;
        if (member_flags.exists(v))
        begin
            if ((member_flags[v] & mask) != 2'b00)
                return 1'b0;
            member_flags[v] |= mask;
            if (member_flags[v] == 2'b11)
            begin
                hit.val  = v;
                hit.full = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (stored_count >= TABLE_SIZE)
        begin
            hit.val  = v;
            hit.full = 1'b1;
            return 1'b1;
        end
        member_flags[v] = mask;
        stored_list.push_back(v);
        stored_count++;
        return 1'b0;
    endfunction

    // one transaction; typed rows supply their own expectation
    task automatic issue(input row_t r);
        hit_t h;
        bit   got;
        start <= 1'b1;
        func  <= r.f;
        value <= r.v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        got = model_set_op(r.f, r.v, h);
        if (r.typed)
        begin
            got    = r.has_hit;
            h.val  = r.hv;
            h.full = r.hfull;
        end
        if (got)
            pending_hits.push_back(h);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic add_item(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v);
        row_t r;
        r = '{f: f, v: v, typed: 1'b0, has_hit: 1'b0, hv: '0, hfull: 1'b0};
        issue(r);
    endtask

    function automatic logic [FUNC_W-1:0] pick_add();
        return ($urandom_range(0, 1) == 0) ? FUNC_ADD_A : FUNC_ADD_B;
    endfunction

    // small pool of values, some sharing buckets, so chains and overlaps are common
    task automatic overlap_round(input int n_items);
        logic [VALUE_W-1:0] pool [$];
        logic [VALUE_W-1:0] base;
        int                 k;
        int                 sel;
        pool.delete();
        for (int i = 0; i < $urandom_range(8, 48); i++)
        begin
            k = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0)
                base = 31'h7FFF_FFFF - 31'(k * 7);
            else
                base = 31'($urandom_range(0, 2000000) + k * 13);
            pool.push_back(base + 31'(BUCKET_CNT * $urandom_range(0, 5)));
        end
        for (int i = 0; i < n_items; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 3)
                add_item(FUNC_NONE, 31'($urandom));
            else if (sel < 5)
                add_item(pick_add(), 31'($urandom));
            else if (sel < 6)
                add_item(FUNC_CLEAR, 31'($urandom));
            else
                add_item(pick_add(), pool[$urandom_range(0, pool.size() - 1)]);
        end
        add_item(FUNC_CLEAR, '0);
    endtask

    // fills the table, then mixes new values (dropped) with stored ones
    task automatic fill_round();
        logic [VALUE_W-1:0] v;
        while (stored_count < TABLE_SIZE)
        begin
            if (stored_count > 0 && $urandom_range(0, 9) == 0)
                v = stored_list[$urandom_range(0, stored_list.size() - 1)];
            else
                v = 31'($urandom);
            add_item(pick_add(), v);
        end
        for (int i = 0; i < 80; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                v = stored_list[$urandom_range(0, stored_list.size() - 1)];
            else
                v = 31'($urandom);
            add_item(pick_add(), v);
        end
        add_item(FUNC_CLEAR, '0);
    endtask

    // result check and activity watchdog
    always @(posedge clk)
    begin
        hit_t e;
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
            if (done)
            begin
                if (pending_hits.size() == 0)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %h full %b",
                                 common_value, table_full);
                end
                else
                begin
                    e = pending_hits.pop_front();
                    if (common_value !== e.val || table_full !== e.full)
                    begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected value %h full %b, got value %h full %b",
                                     e.val, e.full, common_value, table_full);
                    end
                end
            end
        end
    end

    initial
    begin
        row_t dir_rows [$];
        dir_rows = '{
            '{FUNC_ADD_A, 31'h0000_0000, 1'b1, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_A, 31'h0000_0000, 1'b1, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_B, 31'h0000_0000, 1'b1, 1'b1, 31'h0, 1'b0},
            '{FUNC_ADD_B, 31'h0000_0000, 1'b1, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_B, 31'h7FFF_FFFF, 1'b1, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_A, 31'h7FFF_FFFF, 1'b1, 1'b1, 31'h7FFF_FFFF, 1'b0},
            '{FUNC_NONE,  31'h5555_5555, 1'b1, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_A, 31'd1021,      1'b0, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_A, 31'd2042,      1'b0, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_B, 31'd1021,      1'b0, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_B, 31'd2042,      1'b0, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_B, 31'd3063,      1'b0, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_A, 31'd1020,      1'b0, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_B, 31'h2AAA_AAAA, 1'b0, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_A, 31'h2AAA_AAAA, 1'b0, 1'b0, 31'h0, 1'b0},
            '{FUNC_CLEAR, 31'h7FFF_FFFF, 1'b1, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_B, 31'h0000_0000, 1'b1, 1'b0, 31'h0, 1'b0},
            '{FUNC_ADD_A, 31'h0000_0000, 1'b1, 1'b1, 31'h0, 1'b0},
            '{FUNC_ADD_A, 31'd2042,      1'b0, 1'b0, 31'h0, 1'b0},
            '{FUNC_CLEAR, 31'h0000_0000, 1'b1, 1'b0, 31'h0, 1'b0}
        };
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = FUNC_NONE;
        value        = '0;
        stored_count = 0;
        burst_left   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            issue(dir_rows[i]);

        overlap_round(70);
        overlap_round(60);
        fill_round();
        overlap_round(70);
        overlap_round(60);
        start <= 1'b0;

        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);

        if (!failed && pending_hits.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/hsi_pkg.sv
rtl/hsi_ram.sv
rtl/hash_set_intersection.sv
rtl/hsi_checker.sv
test/testbench.sv
